[src/pfa_pkg.sv]
package pfa_pkg;

   // frame table geometry
   localparam int NUM_FRAMES = 1024;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int CUR_W      = 12;
   localparam int OWNER_W    = 16;
   localparam int STATUS_W   = 3;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 2;

   // request types
   localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_VICTIM    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SWAP_REFUSED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE     = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP     = 2'd2;

   // one frame table entry
   typedef struct packed {
      logic               used;
      logic [CNT_W-1:0]   run;
      logic [OWNER_W-1:0] owner;
   } frame_entry_type;

   localparam int ENTRY_W = $bits(frame_entry_type);

endpackage

[src/page_frame_allocator.sv]
// First-fit page frame allocator. A frame table in RAM holds, per frame, a used bit, a run
// length and an owner tag; a small sequencer walks it one entry per clock through the single
// read port of that RAM. An allocate visits at most the managed frame count of table
// positions in a first-fit scan, jumping whole used runs at once, then writes the granted
// run entry by entry. When it falls back to eviction it first wraps the round-robin pointer
// modulo the frame count where needed, then probes up to the frame count of frames. A free
// checks the head entry, then makes a check pass and a clear pass over the run. An initialize
// sweeps all 1024 entries. After reset the same sweep clears the table while req_stall stays
// high; register writes are taken at any time. Requests are handled one at a time; a finished
// response may wait in the output register while the next request is accepted.
module page_frame_allocator (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pfa_pkg::REQ_W-1:0]      req_type,
   input  logic [pfa_pkg::CNT_W-1:0]      req_page_count,
   input  logic [pfa_pkg::OWNER_W-1:0]    req_owner_tag,
   input  logic [pfa_pkg::IDX_W-1:0]      req_frame_index,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pfa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pfa_pkg::IDX_W-1:0]      rsp_first_frame,
   output logic                           rsp_evicted,
   output logic [pfa_pkg::OWNER_W-1:0]    rsp_evicted_owner,
   // register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfa_pkg::CNT_W-1:0]      csr_data
);

   import pfa_pkg::*;

   // sequencer states
   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE      = 4'd0;
   localparam logic [STATE_W-1:0] S_SWEEP     = 4'd1;
   localparam logic [STATE_W-1:0] S_SCAN      = 4'd2;
   localparam logic [STATE_W-1:0] S_GRANT     = 4'd3;
   localparam logic [STATE_W-1:0] S_MOD       = 4'd4;
   localparam logic [STATE_W-1:0] S_VSCAN     = 4'd5;
   localparam logic [STATE_W-1:0] S_FREE_HEAD = 4'd6;
   localparam logic [STATE_W-1:0] S_FREE_CHK  = 4'd7;
   localparam logic [STATE_W-1:0] S_FREE_CLR  = 4'd8;
   localparam logic [STATE_W-1:0] S_DONE      = 4'd9;

   // control registers
   logic [STATE_W-1:0]  state_ff, state_in;
   logic [CUR_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    begin_ff, begin_in;
   logic                open_ff, open_in;
   logic [CNT_W-1:0]    end_ff, end_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [IDX_W-1:0]    vptr_ff, vptr_in;
   logic [CNT_W-1:0]    rsv_ff, rsv_in;
   logic                sweep_rsp_ff, sweep_rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [CNT_W-1:0]    frames_ff, frames_in;
   logic [CNT_W-1:0]    reserved_ff, reserved_in;
   logic                swap_ff, swap_in;

   // request and result holding registers
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [OWNER_W-1:0]  tag_ff, tag_in;
   logic [IDX_W-1:0]    fidx_ff, fidx_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_first_ff, res_first_in;
   logic                res_ev_ff, res_ev_in;
   logic [OWNER_W-1:0]  res_old_ff, res_old_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]    rsp_first_ff;
   logic                rsp_ev_ff;
   logic [OWNER_W-1:0]  rsp_old_ff;
   logic                rsp_load;

   // frame table ports
   logic                ram_wr_en;
   frame_entry_type     ram_wr_data;
   frame_entry_type     rd_ent;

   // derived values
   logic [CNT_W-1:0]    fc;
   logic [CNT_W-1:0]    rsv_lim;
   logic [CUR_W-1:0]    cur_next;
   logic [IDX_W-1:0]    run_begin;
   logic [CNT_W-1:0]    run_have;
   logic [CNT_W-1:0]    skip_len;
   logic [CNT_W-1:0]    vp_first;
   logic [CNT_W:0]      rem_shift;
   logic [CNT_W:0]      rem_sub;
   logic [CNT_W-1:0]    rem_new;
   logic                victim_ok;

   // clamp the frame count and the reserved count
   assign fc      = (frames_ff > CNT_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : frames_ff;
   assign rsv_lim = (reserved_ff > fc) ? fc : reserved_ff;

   assign cur_next  = cur_ff + CUR_W'(1);
   assign run_begin = open_ff ? begin_ff : cur_ff[IDX_W-1:0];
   assign run_have  = cur_ff[CNT_W-1:0] + CNT_W'(1) - CNT_W'(run_begin);
   assign skip_len  = (rd_ent.run == '0) ? CNT_W'(1) : rd_ent.run;
   assign vp_first  = CNT_W'(vptr_ff) + CNT_W'(1);

   // one restoring step of the pointer remainder
   assign rem_shift = {rem_ff, end_ff[CNT_W-1]};
   assign rem_sub   = rem_shift - {1'b0, fc};
   assign rem_new   = (rem_shift >= {1'b0, fc}) ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];

   assign victim_ok = rd_ent.used && (rd_ent.run == CNT_W'(1)) && (rd_ent.owner != '0);

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   pfa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (cur_in[IDX_W-1:0]),
      .rd_data (rd_ent)
   );

   // register writes
   always_comb begin
      frames_in   = frames_ff;
      reserved_in = reserved_ff;
      swap_in     = swap_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAMES:   frames_in   = csr_data;
            CSR_RESERVED: reserved_in = csr_data;
            CSR_SWAP:     swap_in     = csr_data[0];
            default:      ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      begin_in      = begin_ff;
      open_in       = open_ff;
      end_in        = end_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      vptr_in       = vptr_ff;
      rsv_in        = rsv_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      n_in          = n_ff;
      tag_in        = tag_ff;
      fidx_in       = fidx_ff;
      res_status_in = res_status_ff;
      res_first_in  = res_first_ff;
      res_ev_in     = res_ev_ff;
      res_old_in    = res_old_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n_in          = req_page_count;
               tag_in        = req_owner_tag;
               fidx_in       = req_frame_index;
               res_status_in = ST_OK;
               res_first_in  = '0;
               res_ev_in     = 1'b0;
               res_old_in    = '0;
               unique case (req_type)
                  REQ_ALLOC: begin
                     if (req_page_count == '0) begin
                        res_status_in = ST_NO_SPACE;
                        state_in      = S_DONE;
                     end else begin
                        cur_in   = '0;
                        open_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  REQ_FREE: begin
                     if (CNT_W'(req_frame_index) >= fc) begin
                        res_status_in = ST_BAD_FREE;
                        state_in      = S_DONE;
                     end else begin
                        cur_in   = CUR_W'(req_frame_index);
                        state_in = S_FREE_HEAD;
                     end
                  end
                  REQ_INIT: begin
                     cur_in       = '0;
                     rsv_in       = rsv_lim;
                     vptr_in      = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         // rewrite every entry: reserved frames as used runs of one
         S_SWEEP: begin
            ram_wr_en        = 1'b1;
            ram_wr_data.used = (cur_ff < CUR_W'(rsv_ff));
            ram_wr_data.run  = (cur_ff < CUR_W'(rsv_ff)) ? CNT_W'(1) : '0;
            if (cur_ff == CUR_W'(NUM_FRAMES - 1)) begin
               sweep_rsp_in = 1'b0;
               state_in     = sweep_rsp_ff ? S_DONE : S_IDLE;
            end else begin
               cur_in = cur_next;
            end
         end

         // first-fit scan, one table position per cycle
         S_SCAN: begin
            if (cur_ff >= CUR_W'(fc)) begin
               if (!swap_ff) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_DONE;
               end else if (n_ff > CNT_W'(1)) begin
                  res_status_in = ST_SWAP_REFUSED;
                  state_in      = S_DONE;
               end else if (fc == '0) begin
                  res_status_in = ST_NO_VICTIM;
                  state_in      = S_DONE;
               end else if (vp_first < fc) begin
                  cur_in   = CUR_W'(vp_first);
                  cnt_in   = CNT_W'(1);
                  state_in = S_VSCAN;
               end else begin
                  rem_in   = '0;
                  end_in   = vp_first;
                  cnt_in   = '0;
                  state_in = S_MOD;
               end
            end else if (rd_ent.used) begin
               open_in = 1'b0;
               cur_in  = cur_ff + CUR_W'(skip_len);
            end else if (run_have == n_ff) begin
               begin_in = run_begin;
               cur_in   = CUR_W'(run_begin);
               end_in   = CNT_W'(run_begin) + n_ff;
               state_in = S_GRANT;
            end else begin
               open_in  = 1'b1;
               begin_in = run_begin;
               cur_in   = cur_next;
            end
         end

         // write the granted run
         S_GRANT: begin
            ram_wr_en         = 1'b1;
            ram_wr_data.used  = 1'b1;
            ram_wr_data.run   = (cur_ff[IDX_W-1:0] == begin_ff) ? n_ff : '0;
            ram_wr_data.owner = tag_ff;
            if (cur_next == CUR_W'(end_ff)) begin
               res_first_in = begin_ff;
               state_in     = S_DONE;
            end else begin
               cur_in = cur_next;
            end
         end

         // wrap the victim pointer modulo the frame count, one bit a cycle
         S_MOD: begin
            rem_in = rem_new;
            end_in = end_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CNT_W - 1)) begin
               cur_in   = CUR_W'(rem_new);
               cnt_in   = CNT_W'(1);
               state_in = S_VSCAN;
            end
         end

         // round-robin victim probe
         S_VSCAN: begin
            if (victim_ok) begin
               ram_wr_en         = 1'b1;
               ram_wr_data.used  = 1'b1;
               ram_wr_data.run   = CNT_W'(1);
               ram_wr_data.owner = tag_ff;
               vptr_in           = cur_ff[IDX_W-1:0];
               res_first_in      = cur_ff[IDX_W-1:0];
               res_ev_in         = 1'b1;
               res_old_in        = rd_ent.owner;
               state_in          = S_DONE;
            end else if (cnt_ff >= fc) begin
               vptr_in       = cur_ff[IDX_W-1:0];
               res_status_in = ST_NO_VICTIM;
               state_in      = S_DONE;
            end else begin
               cur_in = (cur_next == CUR_W'(fc)) ? '0 : cur_next;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         // check the head entry of the run to free
         S_FREE_HEAD: begin
            if (!rd_ent.used || (rd_ent.run == '0) ||
                (rd_ent.run > (fc - CNT_W'(fidx_ff)))) begin
               res_status_in = ST_BAD_FREE;
               state_in      = S_DONE;
            end else begin
               end_in   = CNT_W'(fidx_ff) + rd_ent.run;
               state_in = S_FREE_CHK;
            end
         end

         // every frame of the run must be used
         S_FREE_CHK: begin
            if (!rd_ent.used) begin
               res_status_in = ST_BAD_FREE;
               state_in      = S_DONE;
            end else if (cur_next == CUR_W'(end_ff)) begin
               cur_in   = CUR_W'(fidx_ff);
               state_in = S_FREE_CLR;
            end else begin
               cur_in = cur_next;
            end
         end

         // release the run, keeping run lengths past the head
         S_FREE_CLR: begin
            ram_wr_en        = 1'b1;
            ram_wr_data.used = 1'b0;
            ram_wr_data.run  = (cur_ff[IDX_W-1:0] == fidx_ff) ? '0 : rd_ent.run;
            if (cur_next == CUR_W'(end_ff)) begin
               state_in = S_DONE;
            end else begin
               cur_in = cur_next;
            end
         end

         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // response beat register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         cur_ff       <= '0;
         begin_ff     <= '0;
         open_ff      <= 1'b0;
         end_ff       <= '0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         vptr_ff      <= '0;
         rsv_ff       <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frames_ff    <= CNT_W'(NUM_FRAMES);
         reserved_ff  <= '0;
         swap_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         begin_ff     <= begin_in;
         open_ff      <= open_in;
         end_ff       <= end_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         vptr_ff      <= vptr_in;
         rsv_ff       <= rsv_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         frames_ff    <= frames_in;
         reserved_ff  <= reserved_in;
         swap_ff      <= swap_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      tag_ff        <= tag_in;
      fidx_ff       <= fidx_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
      res_ev_ff     <= res_ev_in;
      res_old_ff    <= res_old_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_first_ff  <= res_first_ff;
         rsp_ev_ff     <= res_ev_ff;
         rsp_old_ff    <= res_old_ff;
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_first_frame   = rsp_first_ff;
   assign rsp_evicted       = rsp_ev_ff;
   assign rsp_evicted_owner = rsp_old_ff;

endmodule

[src/pfa_ram.sv]
module pfa_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/page_frame_allocator_check.sv]
module page_frame_allocator_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [pfa_pkg::REQ_W-1:0]      req_type,
   input  logic [pfa_pkg::CNT_W-1:0]      req_page_count,
   input  logic [pfa_pkg::OWNER_W-1:0]    req_owner_tag,
   input  logic [pfa_pkg::IDX_W-1:0]      req_frame_index,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [pfa_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [pfa_pkg::IDX_W-1:0]      rsp_first_frame,
   input  logic                           rsp_evicted,
   input  logic [pfa_pkg::OWNER_W-1:0]    rsp_evicted_owner,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfa_pkg::CNT_W-1:0]      csr_data,
   output int                             mismatch_count,
   output int                             outstanding,
   output int                             rsp_count,
   output int                             evict_count,
   output int                             csr_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pfa_pkg::*;

   // one predicted response beat
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    first;
      logic                evicted;
      logic [OWNER_W-1:0]  old_owner;
   } grant_type;

   // shadow frame table and registers
   logic               used_q  [NUM_FRAMES];
   logic [CNT_W-1:0]   run_q   [NUM_FRAMES];
   logic [OWNER_W-1:0] owner_q [NUM_FRAMES];
   int unsigned        victim_ptr;
   logic [CNT_W-1:0]   cfg_frames;
   logic [CNT_W-1:0]   cfg_reserved;
   logic               cfg_swap;
   grant_type          expected_q [$];

   function automatic int unsigned managed_frames();
      return (cfg_frames > NUM_FRAMES) ? NUM_FRAMES : cfg_frames;
   endfunction

   function automatic void clear_table();
      for (int f = 0; f < NUM_FRAMES; f++) begin
         used_q[f]  = 1'b0;
         run_q[f]   = '0;
         owner_q[f] = '0;
      end
      victim_ptr = 0;
   endfunction

   // first-fit scan from frame 0, used runs jumped whole, zero-length run counts as one
   function automatic bit first_fit(input int unsigned fc, input int unsigned want,
                                    output int unsigned start);
      int unsigned pos;
      int unsigned run_begin;
      bit          run_open;
      pos       = 0;
      run_begin = 0;
      run_open  = 1'b0;
      start     = 0;
      while (pos < fc) begin
         if (used_q[pos]) begin
            run_open = 1'b0;
            pos += (run_q[pos] == 0) ? 1 : run_q[pos];
         end else begin
            if (!run_open) begin
               run_begin = pos;
               run_open  = 1'b1;
            end
            pos++;
            if (pos - run_begin == want) begin
               start = run_begin;
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // round-robin probe for a single-frame run with a nonzero owner
   function automatic bit pick_victim(input int unsigned fc, output int unsigned frame);
      int unsigned vp;
      vp    = victim_ptr;
      frame = 0;
      if (fc == 0)
         return 1'b0;
      for (int unsigned i = 0; i < fc; i++) begin
         vp = (vp + 1) % fc;
         if (used_q[vp] && run_q[vp] == 1 && owner_q[vp] != 0) begin
            victim_ptr = vp;
            frame      = vp;
            return 1'b1;
         end
      end
      victim_ptr = vp;
      return 1'b0;
   endfunction

   // apply one request to the shadow table and return the response it causes
   function automatic grant_type predict_grant(input logic [REQ_W-1:0]   kind,
                                               input logic [CNT_W-1:0]   count,
                                               input logic [OWNER_W-1:0] tag,
                                               input logic [IDX_W-1:0]   idx);
      grant_type   g;
      int unsigned fc;
      int unsigned start;
      int unsigned victim;
      int unsigned len;
      int unsigned kept;
      bit          ok;
      g  = '0;
      fc = managed_frames();
      case (kind)
         REQ_ALLOC: begin
            if (count == 0) begin
               g.status = ST_NO_SPACE;
            end else if (first_fit(fc, count, start)) begin
               for (int unsigned i = 0; i < count; i++) begin
                  used_q[start+i]  = 1'b1;
                  owner_q[start+i] = tag;
                  run_q[start+i]   = (i == 0) ? count : '0;
               end
               g.first = IDX_W'(start);
            end else if (!cfg_swap) begin
               g.status = ST_NO_SPACE;
            end else if (count > 1) begin
               g.status = ST_SWAP_REFUSED;
            end else if (!pick_victim(fc, victim)) begin
               g.status = ST_NO_VICTIM;
            end else begin
               g.first          = IDX_W'(victim);
               g.evicted        = 1'b1;
               g.old_owner      = owner_q[victim];
               owner_q[victim] = tag;
               used_q[victim]  = 1'b1;
               run_q[victim]   = CNT_W'(1);
            end
         end
         REQ_FREE: begin
            ok  = (idx < fc) && used_q[idx] && (run_q[idx] != 0);
            len = 0;
            if (ok) begin
               len = run_q[idx];
               ok  = (len <= fc - idx);
            end
            if (ok) begin
               for (int unsigned i = 0; i < len; i++)
                  if (!used_q[idx+i])
                     ok = 1'b0;
            end
            if (!ok) begin
               g.status = ST_BAD_FREE;
            end else begin
               run_q[idx] = '0;
               for (int unsigned i = 0; i < len; i++) begin
                  used_q[idx+i]  = 1'b0;
                  owner_q[idx+i] = '0;
               end
            end
         end
         REQ_INIT: begin
            kept = (cfg_reserved > fc) ? fc : cfg_reserved;
            clear_table();
            for (int unsigned i = 0; i < kept; i++) begin
               used_q[i] = 1'b1;
               run_q[i]  = CNT_W'(1);
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      grant_type got;
      if (reset) begin
         clear_table();
         cfg_frames   = CNT_W'(NUM_FRAMES);
         cfg_reserved = '0;
         cfg_swap     = 1'b1;
         expected_q.delete();
      end else begin
         // register write beat
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAMES:   cfg_frames   = csr_data;
               CSR_RESERVED: cfg_reserved = csr_data;
               CSR_SWAP:     cfg_swap     = csr_data[0];
               default: ;
            endcase
            csr_count++;
         end
         // response beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got.status    = rsp_status;
            got.first     = rsp_first_frame;
            got.evicted   = rsp_evicted;
            got.old_owner = rsp_evicted_owner;
            rsp_count++;
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with none expected: status %0d frame %0d",
                           $realtime, got.status, got.first);
            end else begin
               want = expected_q.pop_front();
               if (got.status !== want.status || got.first !== want.first ||
                   got.evicted !== want.evicted || got.old_owner !== want.old_owner) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch expected status %0d frame %0d evicted %0b",
                               " owner %h, got status %0d frame %0d evicted %0b owner %h"},
                              $realtime, want.status, want.first, want.evicted,
                              want.old_owner, got.status, got.first, got.evicted,
                              got.old_owner);
               end
            end
         end
         // request beat updates the shadow table
         if (req_valid && !req_stall) begin
            want = predict_grant(req_type, req_page_count, req_owner_tag, req_frame_index);
            if (want.evicted)
               evict_count++;
            expected_q.push_back(want);
         end
      end
      outstanding = expected_q.size();
   end

endmodule

[sim/page_frame_allocator_tb.sv]
module page_frame_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pfa_pkg::*;

   localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
   localparam int CYCLE_LIMIT  = 8_000_000;
   localparam int DRAIN_CYCLES = 1100;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 70;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [REQ_W-1:0]     req_type;
   logic [CNT_W-1:0]     req_page_count;
   logic [OWNER_W-1:0]   req_owner_tag;
   logic [IDX_W-1:0]     req_frame_index;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [IDX_W-1:0]     rsp_first_frame;
   logic                 rsp_evicted;
   logic [OWNER_W-1:0]   rsp_evicted_owner;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_data;

   int mismatch_count;
   int outstanding;
   int rsp_count;
   int evict_count;
   int csr_count;
   int idle_pct  = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int settings   = 0;
   int cycle_count = 0;
   int unsigned live_starts [$];

   // random phase settings, extremes and clamped values among them
   int unsigned phase_frames   [PHASES] = '{16, 1024, 8, 40, 32, 2047, 1, 24};
   int unsigned phase_reserved [PHASES] = '{3, 10, 0, 2047, 4, 0, 0, 6};
   bit          phase_swap     [PHASES] = '{1, 1, 1, 1, 0, 1, 1, 0};

   page_frame_allocator DUT (.*);

   page_frame_allocator_check frame_check (.*);

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // granted run starts, used to aim free requests at live runs
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_OK &&
          (rsp_first_frame != 0 || rsp_evicted))
         live_starts.push_back(rsp_first_frame);

   task automatic set_idling(input int mode);
      case (mode)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 73; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 73; end
         default: begin idle_pct = 36; stall_pct = 36; end
      endcase
   endtask

   // one request beat, with a random gap ahead of it
   task automatic send_req(input logic [REQ_W-1:0] kind, input int unsigned count,
                           input logic [OWNER_W-1:0] tag, input logic [IDX_W-1:0] idx);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_page_count  <= CNT_W'(count);
      req_owner_tag   <= tag;
      req_frame_index <= idx;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // hold off requests until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] sel, input logic [CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_config(input int unsigned frames, input int unsigned reserved,
                             input bit swap);
      csr_write(CSR_FRAMES, CNT_W'(frames));
      csr_write(CSR_RESERVED, CNT_W'(reserved));
      csr_write(CSR_SWAP, CNT_W'(swap));
      csr_valid <= 1'b0;
      settings++;
   endtask

   // mostly small allocates and frees of live runs, some noise
   task automatic random_item(input int unsigned fc);
      int unsigned        pick;
      int unsigned        count;
      int unsigned        slot;
      logic [OWNER_W-1:0] tag;
      logic [IDX_W-1:0]   idx;
      pick  = $urandom_range(0, 99);
      tag   = ($urandom_range(0, 4) == 0) ? '0 : OWNER_W'($urandom);
      idx   = IDX_W'($urandom);
      count = $urandom_range(0, 2047);
      if (pick < 55) begin
         case ($urandom_range(0, 19))
            0:          count = 0;
            1:          count = $urandom_range(0, 2047);
            2, 3, 4, 5: count = $urandom_range(1, (fc == 0) ? 1 : fc);
            default:    count = $urandom_range(1, 4);
         endcase
         send_req(REQ_ALLOC, count, tag, idx);
      end else if (pick < 92) begin
         if (live_starts.size() != 0 && $urandom_range(0, 4) != 0) begin
            slot = $urandom_range(0, live_starts.size() - 1);
            idx  = IDX_W'(live_starts[slot]);
            live_starts.delete(slot);
         end else if (fc != 0 && $urandom_range(0, 1) == 0) begin
            idx = IDX_W'($urandom_range(0, fc - 1));
         end
         send_req(REQ_FREE, count, tag, idx);
      end else if (pick < 95) begin
         live_starts.delete();
         send_req(REQ_INIT, count, tag, idx);
      end else begin
         send_req(REQ_SPARE, count, tag, idx);
      end
   endtask

   initial begin
      int unsigned fc;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = REQ_ALLOC;
      req_page_count  = '0;
      req_owner_tag   = '0;
      req_frame_index = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_FRAMES;
      csr_data        = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // small table with two kernel frames
      set_config(8, 2, 1'b1);
      send_req(REQ_INIT, 0, '0, '0);
      send_req(REQ_ALLOC, 0, 16'h0001, '0);
      send_req(REQ_ALLOC, 1024, 16'h0001, '0);
      send_req(REQ_ALLOC, 3, 16'hFFFF, '1);
      send_req(REQ_ALLOC, 1, 16'h0000, '0);
      send_req(REQ_ALLOC, 1, 16'h0001, '0);
      send_req(REQ_ALLOC, 1, 16'h0002, '0);
      // table full: eviction, then multi-page refusal
      send_req(REQ_ALLOC, 1, 16'h0003, '0);
      send_req(REQ_ALLOC, 2, 16'h0004, '0);
      // free inside a run, beyond the table, good, then already free
      send_req(REQ_FREE, 0, '0, 10'd3);
      send_req(REQ_FREE, 0, '0, 10'd1023);
      send_req(REQ_FREE, 0, '0, 10'd2);
      send_req(REQ_FREE, 0, '0, 10'd2);
      send_req(REQ_SPARE, 2047, 16'hFFFF, '1);
      send_req(REQ_ALLOC, 3, 16'h1234, '0);

      // shrink without init: run reaching past the end, no swap
      wait_drained();
      set_config(4, 2, 1'b0);
      send_req(REQ_FREE, 0, '0, 10'd2);
      send_req(REQ_ALLOC, 1, 16'h0005, '0);

      // no managed frames
      wait_drained();
      set_config(0, 5, 1'b1);
      send_req(REQ_ALLOC, 1, 16'h0006, '0);
      send_req(REQ_INIT, 0, '0, '0);
      send_req(REQ_ALLOC, 1, 16'h0006, '0);

      // clamped count, every frame reserved, full victim sweep
      wait_drained();
      set_config(2047, 1024, 1'b1);
      send_req(REQ_INIT, 0, '0, '0);
      send_req(REQ_ALLOC, 1, 16'h0005, '0);
      send_req(REQ_FREE, 0, '0, 10'd0);
      send_req(REQ_ALLOC, 1, 16'hFFFF, '0);
      send_req(REQ_ALLOC, 1, 16'h0009, '0);
      send_req(REQ_FREE, 0, '0, 10'd1023);

      // random phases under each idling mode
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         set_idling(p % 4);
         set_config(phase_frames[p], phase_reserved[p], phase_swap[p]);
         fc = (phase_frames[p] > NUM_FRAMES) ? NUM_FRAMES : phase_frames[p];
         if (p != 4 && p != 6) begin
            live_starts.delete();
            send_req(REQ_INIT, $urandom_range(0, 2047), OWNER_W'($urandom), IDX_W'($urandom));
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == PHASE_ITEMS / 2)
               wait_drained();
            random_item(fc);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d requests over %0d register settings (%0d register writes)",
               items_sent, settings, csr_count);
      $display("%0d responses checked, %0d evictions, %0d mismatches, %0d outstanding",
               rsp_count, evict_count, mismatch_count, outstanding);
      if (mismatch_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[files.f]
src/pfa_pkg.sv
src/pfa_ram.sv
src/page_frame_allocator.sv
sim/page_frame_allocator_check.sv
sim/page_frame_allocator_tb.sv
